@@ hdl/bitplane_tile_row_renderer_macros.svh @@
// ----------------------------------------------------------------------------
// bitplane_tile_row_renderer_macros
// assertion macros used by the renderer top level
// ----------------------------------------------------------------------------
`ifndef BITPLANE_TILE_ROW_RENDERER_MACROS_SVH
`define BITPLANE_TILE_ROW_RENDERER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, ignored while reset is high
`define BTR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication, ignored while reset is high
`define BTR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define BTR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BTR_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/btr_pkg.sv @@
// ----------------------------------------------------------------------------
// btr_pkg
// shared constants, codes and the controller command bundle
// ----------------------------------------------------------------------------
package btr_pkg;

  // parameter defaults
  localparam int MEM_ADDR_BITS_DEF = 16;
  localparam int CELL_ROWS_DEF     = 24;

  // port widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // item kinds carried on tuser
  localparam logic ACTION_WRITE  = 1'b0;
  localparam logic ACTION_RENDER = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_PAGE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BANK   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_ALWAYS = 2'd2;

  // memory address source; plane codes double as the plane offset / 8
  localparam logic [1:0] SEL_NAME   = 2'd0;
  localparam logic [1:0] SEL_PLANE0 = 2'd1;
  localparam logic [1:0] SEL_PLANE1 = 2'd2;
  localparam logic [1:0] SEL_PLANE2 = 2'd3;

  // glyph source and visible area limits
  localparam logic [7:0]  CODE_RAM_MIN  = 8'hE0;
  localparam logic [16:0] RAM_GLYPH_OFS = 17'h00400;
  localparam logic [4:0]  COL_FIRST     = 5'd2;
  localparam logic [4:0]  COL_LAST      = 5'd29;

  // controller to datapath commands
  typedef struct packed {
    logic       item_load;
    logic       mem_we;
    logic       mem_re;
    logic [1:0] addr_sel;
    logic       code_load;
    logic       plane0_load;
    logic       plane1_load;
    logic       out_load;
  } cmd_t;

endpackage

@@ hdl/btr_ctrl.sv @@
// ----------------------------------------------------------------------------
// btr_ctrl
// sequencer: one name read then three plane reads per render beat
// ----------------------------------------------------------------------------
module btr_ctrl
  import btr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RD_P0  = 3'd1;
  localparam logic [2:0] ST_RD_P1  = 3'd2;
  localparam logic [2:0] ST_RD_P2  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       out_free;
  logic       accept;
  logic       render;

  // output register can take a new result
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) || ((state == ST_FINISH) && out_free);
  assign accept   = in_valid && in_ready;
  assign render   = accept && (in_kind == ACTION_RENDER);

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.mem_we    = accept && (in_kind == ACTION_WRITE);
    cmd.item_load = render;
    cmd.mem_re    = render;
    cmd.addr_sel  = SEL_NAME;
    case (state)
      ST_IDLE: begin
        if (render) state_next = ST_RD_P0;
      end
      ST_RD_P0: begin
        cmd.code_load = 1'b1;
        cmd.mem_re    = 1'b1;
        cmd.addr_sel  = SEL_PLANE0;
        state_next    = ST_RD_P1;
      end
      ST_RD_P1: begin
        cmd.plane0_load = 1'b1;
        cmd.mem_re      = 1'b1;
        cmd.addr_sel    = SEL_PLANE1;
        state_next      = ST_RD_P2;
      end
      ST_RD_P2: begin
        cmd.plane1_load = 1'b1;
        cmd.mem_re      = 1'b1;
        cmd.addr_sel    = SEL_PLANE2;
        state_next      = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.out_load = out_free;
        if (out_free) begin
          state_next = render ? ST_RD_P0 : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ hdl/btr_datapath.sv @@
// ----------------------------------------------------------------------------
// btr_datapath
// video memory, config registers, address generation and pixel assembly
// ----------------------------------------------------------------------------
module btr_datapath
  import btr_pkg::*;
#(
  parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF,
  parameter int CELL_ROWS     = CELL_ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int         MEM_DEPTH = 1 << MEM_ADDR_BITS;
  localparam logic [5:0] ROW_LIMIT = 6'(CELL_ROWS);

  logic [7:0]               mem [MEM_DEPTH];
  logic [7:0]               rdata;
  logic [MEM_ADDR_BITS-1:0] mem_addr;

  logic [7:0] name_page;
  logic       pattern_bank;
  logic       pattern_always;

  logic [15:0] wr_address;
  logic [7:0]  wr_data;
  logic [4:0]  in_column;
  logic [4:0]  in_row;
  logic [2:0]  in_line;

  logic [2:0]  line_q;
  logic        blank_q;
  logic        blank;
  logic [7:0]  code_q;
  logic [7:0]  code_cur;
  logic [7:0]  plane0;
  logic [7:0]  plane1;

  logic [16:0] name_addr;
  logic [16:0] glyph_base;
  logic [16:0] plane_addr;
  logic [16:0] rd_addr;

  // unpack the input beat
  assign wr_address = in_data[15:0];
  assign wr_data    = in_data[23:16];
  assign in_column  = in_data[28:24];
  assign in_row     = in_data[33:29];
  assign in_line    = in_data[36:34];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      name_page      <= '0;
      pattern_bank   <= 1'b0;
      pattern_always <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NAME_PAGE:      name_page      <= cfg_data;
        REG_PATTERN_BANK:   pattern_bank   <= cfg_data[0];
        REG_PATTERN_ALWAYS: pattern_always <= cfg_data[0];
        default:            ;
      endcase
    end
  end

  // border columns and rows past the screen render black
  assign blank = (in_column < COL_FIRST) || (in_column > COL_LAST) ||
                 ({1'b0, in_row} >= ROW_LIMIT);

  // name table address from the live input beat
  assign name_addr = {1'b0, name_page, 8'h00} + {7'b0, in_row, 5'b0} +
                     {12'b0, in_column};

  // code comes straight from memory in the first plane cycle
  assign code_cur = cmd.code_load ? rdata : code_q;

  // glyph base: pattern bank or glyph ram above the name table
  always_comb begin
    if ((code_cur < CODE_RAM_MIN) || pattern_always) begin
      glyph_base = {3'b0, pattern_bank, 13'b0} + {4'b0, code_cur, 5'b0};
    end else begin
      glyph_base = {1'b0, name_page, 8'h00} + RAM_GLYPH_OFS +
                   {7'b0, code_cur[4:0], 5'b0};
    end
  end

  assign plane_addr = glyph_base + {12'b0, cmd.addr_sel, line_q};
  assign rd_addr    = (cmd.addr_sel == SEL_NAME) ? name_addr : plane_addr;
  assign mem_addr   = cmd.mem_we ? wr_address[MEM_ADDR_BITS-1:0]
                                 : rd_addr[MEM_ADDR_BITS-1:0];

  // single-port video memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[mem_addr] <= wr_data;
    end
    if (cmd.mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      line_q  <= in_line;
      blank_q <= blank;
    end
    if (cmd.code_load) begin
      code_q <= rdata;
    end
    if (cmd.plane0_load) begin
      plane0 <= rdata;
    end
    if (cmd.plane1_load) begin
      plane1 <= rdata;
    end
  end

  // result register: msb of each plane is the leftmost pixel
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int i = 0; i < 8; i++) begin
        out_data[3*i +: 3] <= blank_q ? 3'b000
                                      : {rdata[7-i], plane1[7-i], plane0[7-i]};
      end
    end
  end

endmodule

@@ hdl/bitplane_tile_row_renderer.sv @@
// ----------------------------------------------------------------------------
// bitplane_tile_row_renderer
// renders one 8-pixel line of a three-plane character cell from video memory
// ----------------------------------------------------------------------------
// write beat: one every cycle while in IDLE, or in FINISH with the output free
// render beat: four reads (name byte, three plane bytes) on the single memory
//   port; result loaded in FINISH, where a next render waits for a free output
// reset: synchronous, clears sequencer, result valid and config registers;
//   video memory content is undefined until written, no clearing pass
// ----------------------------------------------------------------------------
`include "bitplane_tile_row_renderer_macros.svh"

module bitplane_tile_row_renderer
  import btr_pkg::*;
#(
  parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF,
  parameter int CELL_ROWS     = CELL_ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // mem_address, mem_data, cell_column, cell_row, cell_line, zero pad (3)
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6, pixel_7
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t cmd;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  btr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_kind   (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  btr_datapath #(
    .MEM_ADDR_BITS (MEM_ADDR_BITS),
    .CELL_ROWS     (CELL_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (s_axis_tdata),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (m_axis_tdata)
  );

  // checks
  `BTR_ASSERT_IMP(a_port_exclusive, clk, rst, cmd.mem_we, !cmd.mem_re)
  `BTR_ASSERT_NXT(a_render_fetch, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACTION_RENDER), cmd.code_load && cmd.mem_re)
  `BTR_ASSERT_IMP(a_no_overwrite, clk, rst, m_axis_tvalid && !m_axis_tready, !cmd.out_load)
  `BTR_ASSERT_NXT(a_result_shown, clk, rst, cmd.out_load, m_axis_tvalid)

endmodule
